/* design/ptdb_pkg.sv */
// shared types, codes and constants of the periodic tick divider bank
package ptdb_pkg;

  localparam int NUM_ENTRIES_DEF = 4;
  localparam int MAX_ENTRIES     = 4;

  localparam int CNT_W       = 32;
  localparam int ACT_W       = 3;
  localparam int IDX_W       = 2;
  localparam int ENT_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int BIT_CNT_W   = $clog2(CNT_W);
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CNT_W-1:0]     DIV_INVALID = 32'hffffffff;
  localparam logic [BIT_CNT_W-1:0] BIT_LAST    = BIT_CNT_W'(CNT_W - 1);

  // action codes
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STOP   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LOCK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_UNLOCK = 3'd4;
  localparam logic [ACT_W-1:0] ACT_BEGIN  = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIV0       = 3'd2;

  typedef struct packed {
    logic             apply;
    logic             load;
    logic             step;
    logic             last;
    logic             publish;
    logic [ENT_W-1:0] ent;
  } ptdb_cmd_t;

  typedef struct packed {
    logic             tick_go;
    logic             entry_live;
    logic [ENT_W-1:0] scan_n;
  } ptdb_status_t;

endpackage

/* design/ptdb_ctrl.sv */
// controller: sequences apply, per-entry remainder scan and result hand-off
module ptdb_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  ptdb_pkg::ptdb_status_t status,
  output ptdb_pkg::ptdb_cmd_t    cmd
);
  import ptdb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state, state_next;
  logic [ENT_W-1:0]     ent, ent_next;
  logic [BIT_CNT_W-1:0] bit_cnt, bit_cnt_next;

  always_comb begin
    state_next   = state;
    ent_next     = ent;
    bit_cnt_next = bit_cnt;
    cmd          = '0;
    cmd.ent      = ent;
    s_tready     = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.apply  = 1'b1;
          ent_next   = '0;
          state_next = status.tick_go ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (ent >= status.scan_n) begin
          state_next = S_DONE;
        end else if (status.entry_live) begin
          cmd.load     = 1'b1;
          bit_cnt_next = '0;
          state_next   = S_DIV;
        end else begin
          ent_next = ent + 1'b1;
        end
      end
      S_DIV: begin
        cmd.step     = 1'b1;
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == BIT_LAST) begin
          cmd.last   = 1'b1;
          ent_next   = ent + 1'b1;
          state_next = S_SCAN;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ent      <= '0;
      bit_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      ent     <= ent_next;
      bit_cnt <= bit_cnt_next;
      if (cmd.publish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* design/ptdb_dp.sv */
// datapath: registers, timer state, serial remainder unit and result register
module ptdb_dp #(
  parameter int NUM_ENTRIES = ptdb_pkg::NUM_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [ptdb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptdb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [ptdb_pkg::ACT_W-1:0]       in_action,
  input  logic [ptdb_pkg::IDX_W-1:0]       in_entry_index,
  input  ptdb_pkg::ptdb_cmd_t              cmd,
  output ptdb_pkg::ptdb_status_t           status,
  output logic [ptdb_pkg::MAX_ENTRIES-1:0] out_fire_mask,
  output logic [ptdb_pkg::CNT_W-1:0]       out_tick_count,
  output logic                             out_running
);
  import ptdb_pkg::*;

  logic [CNT_W-1:0]       wrap_limit;
  logic [ENT_W-1:0]       entries_in_use;
  logic [CNT_W-1:0]       dividers [NUM_ENTRIES];

  logic [CNT_W-1:0]       counter;
  logic [NUM_ENTRIES-1:0] enables;
  logic                   running;
  logic                   just_begun;
  logic                   locked;

  logic [NUM_ENTRIES-1:0] mask;
  logic [CNT_W-1:0]       rem;
  logic [CNT_W-1:0]       dividend;
  logic [CNT_W-1:0]       div_sel;
  logic [CNT_W-1:0]       div_cur;
  logic                   en_sel;
  logic [CNT_W:0]         trial;
  logic [CNT_W:0]         rem_next;
  logic [ENT_W-1:0]       idx_ext;

  // divider and enable of the entry under scan
  always_comb begin
    div_sel = '0;
    en_sel  = 1'b0;
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      if (cmd.ent == ENT_W'(k)) begin
        div_sel = dividers[k];
        en_sel  = enables[k];
      end
    end
  end

  assign idx_ext = ENT_W'(in_entry_index);

  always_comb begin
    status.tick_go    = (in_action == ACT_TICK) && running && !locked;
    status.entry_live = en_sel && (div_sel != '0) && (div_sel != DIV_INVALID);
    status.scan_n     = (entries_in_use > ENT_W'(NUM_ENTRIES)) ?
                        ENT_W'(NUM_ENTRIES) : entries_in_use;
  end

  // one restoring remainder step per cycle
  assign trial    = {rem, dividend[CNT_W-1]};
  assign rem_next = (trial >= {1'b0, div_cur}) ? (trial - {1'b0, div_cur}) : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_limit     <= '0;
      entries_in_use <= '0;
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        dividers[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_WRAP_LIMIT) begin
        wrap_limit <= cfg_wdata[CNT_W-1:0];
      end
      if (cfg_index == REG_ENTRIES) begin
        entries_in_use <= cfg_wdata[ENT_W-1:0];
      end
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        if (cfg_index == REG_DIV0 + CFG_IDX_W'(k)) begin
          dividers[k] <= cfg_wdata[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter    <= '0;
      enables    <= '0;
      running    <= 1'b0;
      just_begun <= 1'b0;
      locked     <= 1'b0;
    end else if (cmd.apply) begin
      case (in_action)
        ACT_TICK: begin
          if (status.tick_go) begin
            if (counter >= wrap_limit) begin
              counter    <= just_begun ? '0 : CNT_W'(1);
              just_begun <= 1'b0;
            end else begin
              counter <= counter + 1'b1;
            end
          end
        end
        ACT_START: begin
          for (int k = 0; k < NUM_ENTRIES; k++) begin
            if (idx_ext == ENT_W'(k)) enables[k] <= 1'b1;
          end
        end
        ACT_STOP: begin
          for (int k = 0; k < NUM_ENTRIES; k++) begin
            if (idx_ext == ENT_W'(k)) enables[k] <= 1'b0;
          end
        end
        ACT_LOCK:   locked <= 1'b1;
        ACT_UNLOCK: locked <= 1'b0;
        ACT_BEGIN: begin
          locked     <= 1'b0;
          running    <= (wrap_limit != '0);
          just_begun <= (wrap_limit != '0);
          counter    <= wrap_limit;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      mask <= '0;
    end else if (cmd.step && cmd.last && (rem_next == '0)) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        if (cmd.ent == ENT_W'(k)) mask[k] <= 1'b1;
      end
    end
    if (cmd.load) begin
      rem      <= '0;
      dividend <= counter;
      div_cur  <= div_sel;
    end else if (cmd.step) begin
      rem      <= rem_next[CNT_W-1:0];
      dividend <= {dividend[CNT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_fire_mask  <= MAX_ENTRIES'(mask);
      out_tick_count <= counter;
      out_running    <= running;
    end
  end

endmodule

/* design/periodic_tick_divider_bank.sv */
// top level of the periodic tick divider bank
//
//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  s_tdata: action, entry_index
//  m_axis    out  m_tvalid/m_tready  m_tdata: fire_mask, tick_count, running
//  cfg       in   cfg_wr_en          cfg_index, cfg_wdata
//
// a tick that advances the counter scans the entries in use, and each live entry
// runs a 32-step serial remainder, one bit a cycle
// every other item, a locked or stopped tick too, skips the scan
// one item is in flight at a time; a finished result waits in the output
// register while the next item is accepted
// rst is synchronous and clears the configuration, timer and control state;
// the scan and output registers are not reset
module periodic_tick_divider_bank #(
  parameter int NUM_ENTRIES = ptdb_pkg::NUM_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [ptdb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptdb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [2:0] action, [4:3] entry_index, [7:5] zero
  input  logic [ptdb_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [3:0] fire_mask, [35:4] tick_count, [36] running, [39:37] zero
  output logic [ptdb_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import ptdb_pkg::*;

  ptdb_cmd_t              cmd;
  ptdb_status_t           status;
  logic [MAX_ENTRIES-1:0] fire_mask;
  logic [CNT_W-1:0]       tick_count;
  logic                   running;

  ptdb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ptdb_dp #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_action      (s_tdata[ACT_W-1:0]),
    .in_entry_index (s_tdata[ACT_W+IDX_W-1:ACT_W]),
    .cmd            (cmd),
    .status         (status),
    .out_fire_mask  (fire_mask),
    .out_tick_count (tick_count),
    .out_running    (running)
  );

  assign m_tdata = {3'b000, running, tick_count, fire_mask};

endmodule

/* design/ptdb_checker.sv */
// port-level checks of the periodic tick divider bank, bound to the top level
module ptdb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // no result straight out of reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // one item at a time: busy after a transaction
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in work");

  // a stopped module keeps its counter at zero and fires nothing
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[36] |-> (m_tdata[35:4] == 32'd0) && (m_tdata[3:0] == 4'd0))
    else $error("stopped module shows count or fire");

endmodule

bind periodic_tick_divider_bank ptdb_checker u_ptdb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/periodic_tick_divider_bank_test.sv */
// self-checking testbench for the periodic tick divider bank: directed and random actions
module periodic_tick_divider_bank_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ptdb_pkg::*;

  localparam logic [ACT_W-1:0]     ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0]     ACT_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int ITEM_TARGET  = 1950;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [2:0]       pad;
    logic             running;
    logic [CNT_W-1:0] tick_count;
    logic [3:0]       fire_mask;
  } tick_result_t;

  class tick_bank_model;
    logic [CNT_W-1:0]       wrap_limit;
    logic [ENT_W-1:0]       entries_in_use;
    logic [CNT_W-1:0]       divider [MAX_ENTRIES];
    logic [CNT_W-1:0]       counter;
    logic [MAX_ENTRIES-1:0] enables;
    logic                   running;
    logic                   just_begun;
    logic                   locked;
    tick_result_t           expected_q[$];
    int                     mismatches;

    function new();
      wrap_limit = '0;
      entries_in_use = '0;
      foreach (divider[e]) divider[e] = '0;
      counter = '0;
      enables = '0;
      running = 1'b0;
      just_begun = 1'b0;
      locked = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_WRAP_LIMIT) wrap_limit = value;
      else if (idx == REG_ENTRIES) entries_in_use = value[ENT_W-1:0];
      else if (idx >= REG_DIV0 && int'(idx) < int'(REG_DIV0) + MAX_ENTRIES)
        divider[idx - REG_DIV0] = value;
    endfunction

    function void note_item(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx);
      tick_result_t want;
      int scan;
      want = '0;
      case (act)
        ACT_TICK: begin
          if (!locked && running) begin
            if (counter >= wrap_limit) begin
              if (just_begun) begin
                just_begun = 1'b0;
                counter = '0;
              end else begin
                counter = 1;
              end
            end else begin
              counter = counter + 1;
            end
            scan = (entries_in_use > NUM_ENTRIES_DEF) ? NUM_ENTRIES_DEF : entries_in_use;
            for (int e = 0; e < scan; e++) begin
              if (enables[e] && divider[e] != 0 && divider[e] != DIV_INVALID &&
                  (counter % divider[e]) == 0)
                want.fire_mask[e] = 1'b1;
            end
          end
        end
        ACT_START: if (idx < NUM_ENTRIES_DEF) enables[idx] = 1'b1;
        ACT_STOP:  if (idx < NUM_ENTRIES_DEF) enables[idx] = 1'b0;
        ACT_LOCK:   locked = 1'b1;
        ACT_UNLOCK: locked = 1'b0;
        ACT_BEGIN: begin
          locked = 1'b0;
          running = (wrap_limit != 0);
          just_begun = (wrap_limit != 0);
          counter = wrap_limit;
        end
        default: ;
      endcase
      want.tick_count = counter;
      want.running = running;
      expected_q.push_back(want);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      tick_result_t got;
      tick_result_t want;
      got = tdata;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %h arrived with nothing pending", tdata);
        return;
      end
      want = expected_q.pop_front();
      if (got.fire_mask !== want.fire_mask || got.tick_count !== want.tick_count ||
          got.running !== want.running || got.pad !== 3'b000) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: fire_mask %h/%h tick_count %h/%h running %b/%b pad %b",
                   want.fire_mask, got.fire_mask, want.tick_count, got.tick_count,
                   want.running, got.running, got.pad);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  tick_bank_model book;
  int  cycles = 0;
  int  items_sent = 0;
  bit  hold_request = 1'b0;
  bit  sender_gaps_on = 1'b1;

  periodic_tick_divider_bank dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("periodic_tick_divider_bank verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_result(m_tdata);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: ready stretches, random stalls and a long hold-off on request
  initial begin
    int hold_left;
    int stall_left;
    int ready_left;
    hold_left = 0;
    stall_left = 0;
    ready_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (ready_left > 0) begin
          ready_left--;
        end else begin
          ready_left = $urandom_range(0, 40);
          stall_left = pick_gap();
        end
      end
    end
  end

  task automatic send_item(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx);
    int gap;
    cfg_wr_en <= 1'b0;
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, idx, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_item(act, idx);
    if (act <= ACT_BEGIN) items_sent++;
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // write enable is lowered by the next send_item
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    book.set_reg(idx, value);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (book.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int phase;
    int r;
    int n;
    bit full;
    bit well;
    logic [CNT_W-1:0] div;
    logic [CNT_W-1:0] lcm;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
    logic [CNT_W-1:0] t;

    book = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: firing pattern, lock, stop, ignored codes and registers
    write_reg(REG_WRAP_LIMIT, 12);
    write_reg(REG_ENTRIES, 4);
    write_reg(REG_DIV0, 2);
    write_reg(CFG_IDX_W'(REG_DIV0 + 1), 3);
    write_reg(CFG_IDX_W'(REG_DIV0 + 2), 4);
    write_reg(CFG_IDX_W'(REG_DIV0 + 3), DIV_INVALID);
    write_reg(REG_SPARE_LO, 32'h5a5a_a5a5);
    write_reg(REG_SPARE_HI, 32'hffff_ffff);
    send_item(ACT_TICK, IDX_W'(0));
    for (int e = 0; e < MAX_ENTRIES; e++) send_item(ACT_START, IDX_W'(e));
    send_item(ACT_BEGIN, IDX_W'(3));
    repeat (4) send_item(ACT_TICK, IDX_W'(2));
    send_item(ACT_LOCK, IDX_W'(0));
    send_item(ACT_TICK, IDX_W'(1));
    send_item(ACT_UNLOCK, IDX_W'(0));
    send_item(ACT_STOP, IDX_W'(1));
    send_item(ACT_TICK, IDX_W'(3));
    send_item(ACT_SPARE_LO, IDX_W'(1));
    send_item(ACT_SPARE_HI, IDX_W'(2));

    // limit lowered below the counter while running
    wait_idle();
    write_reg(REG_WRAP_LIMIT, 2);
    send_item(ACT_TICK, IDX_W'(0));

    // zero limit keeps the module stopped
    wait_idle();
    write_reg(REG_WRAP_LIMIT, 0);
    send_item(ACT_BEGIN, IDX_W'(0));
    send_item(ACT_TICK, IDX_W'(0));

    // largest limit and dividers, entry count above the bank size
    wait_idle();
    write_reg(REG_WRAP_LIMIT, 32'hffff_ffff);
    write_reg(REG_ENTRIES, 7);
    write_reg(REG_DIV0, 32'hffff_fffe);
    write_reg(CFG_IDX_W'(REG_DIV0 + 1), 0);
    write_reg(CFG_IDX_W'(REG_DIV0 + 2), 1);
    send_item(ACT_BEGIN, IDX_W'(0));
    send_item(ACT_TICK, IDX_W'(0));
    send_item(ACT_TICK, IDX_W'(0));

    // no entries scanned
    wait_idle();
    write_reg(REG_ENTRIES, 0);
    send_item(ACT_TICK, IDX_W'(0));

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      phase++;
      full = (phase == 1) || ($urandom_range(0, 2) == 0);
      for (int e = 0; e < MAX_ENTRIES; e++) begin
        if (full || $urandom_range(0, 1)) begin
          r = $urandom_range(0, 99);
          if (r < 5) div = 0;
          else if (r < 10) div = DIV_INVALID;
          else if (r < 14) div = 32'hffff_fffe;
          else if (r < 84) div = $urandom_range(1, 12);
          else div = $urandom();
          write_reg(CFG_IDX_W'(REG_DIV0 + e), div);
        end
      end
      // least common multiple of the small dividers
      lcm = 1;
      for (int e = 0; e < MAX_ENTRIES; e++) begin
        if (book.divider[e] >= 1 && book.divider[e] <= 12) begin
          a = lcm;
          b = book.divider[e];
          while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
          end
          lcm = lcm / a * book.divider[e];
        end
      end
      if (full || $urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        if (r < 40) div = lcm;
        else if (r < 75) div = $urandom_range(1, 40);
        else if (r < 82) div = 0;
        else if (r < 90) div = '1;
        else div = $urandom();
        write_reg(REG_WRAP_LIMIT, div);
      end
      if (full || $urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        write_reg(REG_ENTRIES, (r < 70) ? 4 : {$urandom_range(0, 1) ? 29'h0 : 29'h1fff_ffff,
                                                3'($urandom_range(0, 7))});
      end

      if (phase == 4) begin
        // output held off while the sender keeps offering ticks
        send_item(ACT_BEGIN, IDX_W'(0));
        hold_request = 1'b1;
        sender_gaps_on = 1'b0;
        repeat (12) send_item(ACT_TICK, IDX_W'($urandom_range(0, 3)));
        sender_gaps_on = 1'b1;
      end

      n = $urandom_range(15, 60);
      well = ($urandom_range(0, 9) < 7);
      if (well) begin
        if ($urandom_range(0, 3) != 0) send_item(ACT_BEGIN, IDX_W'($urandom_range(0, 3)));
        for (int e = 0; e < MAX_ENTRIES; e++)
          if ($urandom_range(0, 2) != 0) send_item(ACT_START, IDX_W'(e));
      end
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (!well) send_item(ACT_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 3)));
        else if (r < 72) send_item(ACT_TICK, IDX_W'($urandom_range(0, 3)));
        else if (r < 77) send_item(ACT_START, IDX_W'($urandom_range(0, 3)));
        else if (r < 81) send_item(ACT_STOP, IDX_W'($urandom_range(0, 3)));
        else if (r < 85) send_item(ACT_LOCK, IDX_W'($urandom_range(0, 3)));
        else if (r < 92) send_item(ACT_UNLOCK, IDX_W'($urandom_range(0, 3)));
        else if (r < 95) send_item(ACT_BEGIN, IDX_W'($urandom_range(0, 3)));
        else send_item((r < 98) ? ACT_SPARE_LO : ACT_SPARE_HI, IDX_W'($urandom_range(0, 3)));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.expected_q.size() == 0) begin
      $display("periodic_tick_divider_bank verification clean");
    end else begin
      $display("periodic_tick_divider_bank verification failed");
    end
    $finish;
  end

endmodule

/* periodic_tick_divider_bank.f */
design/ptdb_pkg.sv
design/ptdb_ctrl.sv
design/ptdb_dp.sv
design/periodic_tick_divider_bank.sv
design/ptdb_checker.sv
tb/periodic_tick_divider_bank_test.sv
